// File: design/obb_pkg.sv
// Constants for the oriented box overlap pipeline: CORDIC table and widths.
`default_nettype none
package obb_pkg;

    localparam int DEF_COORD_WIDTH = 24;
    localparam int DEF_ANGLE_WIDTH = 16;

    localparam int CORDIC_STEPS = 16;
    localparam int CORD_W       = 34;
    localparam int PH_W         = 32;
    localparam int TRIG_W       = 16;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] Q15_MAX     = 16'sd32767;

    localparam logic [PH_W-1:0] ATAN_PHASE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

endpackage
`default_nettype wire

// File: design/oriented_box_overlap_test.sv
// Top level: pipelined separating axis overlap test for two rotated rectangles.
//
// Usage
//   Input stream s_tvalid/s_tready/s_tdata carries one box pair per item:
//   both boxes as centre x, centre y, width, height, angle (see tdata comment).
//   Output stream m_tvalid/m_tready/m_tdata carries one item per input item,
//   with the overlap flag in bit 0 (1 when the boxes touch or overlap).
// Pipeline stages and throughput
//   Stages from acceptance to m_tvalid: 16 CORDIC step registers (one per
//   rotation step, both boxes side by side), a rounding and quadrant stage,
//   the box offset multipliers, corner assembly, axis projection products,
//   projection sums, interval min/max and the final interval compare.
//   One item per cycle sustained while m_tready is not held low; the CORDIC chain sets the depth.
// Reset
//   rst_n clears every stage valid bit; payload registers are not reset.
// Back-pressure
//   When m_tvalid is high and m_tready low the whole pipeline holds, and
//   s_tready drops in the same cycle; nothing is lost or repeated. Bubbles
//   inside the pipeline hold as well and are not squeezed out by a stall.
`default_nettype none
module oriented_box_overlap_test
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH,
    localparam int BOX_W  = 4 * COORD_WIDTH - 2 + ANGLE_WIDTH,
    localparam int TDATA_W = ((2 * BOX_W + 7) / 8) * 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // per box, low bits up: center_x, center_y, width, height, angle; a then b
    input  wire logic [TDATA_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // overlap
    output logic [7:0]              m_tdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = ANGLE_WIDTH;
    localparam int OFF_CY = CW;
    localparam int OFF_W  = 2 * CW;
    localparam int OFF_H  = 3 * CW - 1;
    localparam int OFF_A  = 4 * CW - 2;
    localparam int NST    = CORDIC_STEPS + 7;
    localparam int ST_RND = CORDIC_STEPS;
    localparam int ST_PRM = CORDIC_STEPS + 3;
    localparam int P_W    = CW + TRIG_W;
    localparam int X_W    = CW + TRIG_W + 2;
    localparam int PX_W   = CW + 3;
    localparam int PR_W   = PX_W + TRIG_W;
    localparam int SUM_W  = PR_W + 1;

    logic en;
    logic [NST-1:0] v_reg;

    assign en       = !v_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], s_tvalid};
        end
    end

    // ---------------- CORDIC chain ----------------
    logic signed [CORD_W-1:0] cx_reg [CORDIC_STEPS][2];
    logic signed [CORD_W-1:0] cy_reg [CORDIC_STEPS][2];
    logic signed [PH_W-1:0]   cz_reg [CORDIC_STEPS][2];
    logic [TDATA_W-1:0]       d_reg  [ST_RND+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= s_tdata;
            for (int s = 1; s <= ST_RND; s++)
            begin
                d_reg[s] <= d_reg[s-1];
            end
        end
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++)
    begin : g_cordic
        for (genvar gb = 0; gb < 2; gb++)
        begin : g_box
            logic signed [CORD_W-1:0] xi;
            logic signed [CORD_W-1:0] yi;
            logic signed [PH_W-1:0]   zi;
            logic signed [PH_W-1:0]   at;

            assign at = $signed(ATAN_PHASE[gi]);
            if (gi == 0)
            begin : g_first
                assign xi = CORDIC_GAIN;
                assign yi = '0;
                assign zi = $signed(PH_W'({s_tdata[gb*BOX_W+OFF_A +: AW-2],
                                           {(32-AW){1'b0}}}));
            end
            else
            begin : g_next
                assign xi = cx_reg[gi-1][gb];
                assign yi = cy_reg[gi-1][gb];
                assign zi = cz_reg[gi-1][gb];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!zi[PH_W-1])
                    begin
                        cx_reg[gi][gb] <= xi - (yi >>> gi);
                        cy_reg[gi][gb] <= yi + (xi >>> gi);
                        cz_reg[gi][gb] <= zi - at;
                    end
                    else
                    begin
                        cx_reg[gi][gb] <= xi + (yi >>> gi);
                        cy_reg[gi][gb] <= yi - (xi >>> gi);
                        cz_reg[gi][gb] <= zi + at;
                    end
                end
            end
        end
    end

    // ---------------- round, clamp, quadrant ----------------
    function automatic logic signed [TRIG_W-1:0] rnd_q15(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W-1:0] r;
        r = (v + CORD_W'(16384)) >>> 15;
        if (r > CORD_W'(Q15_MAX))
            return Q15_MAX;
        else if (r < -CORD_W'(Q15_MAX))
            return -Q15_MAX;
        else
            return TRIG_W'(r);
    endfunction

    logic signed [TRIG_W-1:0] cs_reg [ST_RND:ST_PRM-1][2];
    logic signed [TRIG_W-1:0] sn_reg [ST_RND:ST_PRM-1][2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 2; b++)
            begin
                logic signed [TRIG_W-1:0] c;
                logic signed [TRIG_W-1:0] s;
                logic [1:0] q;
                c = rnd_q15(cx_reg[CORDIC_STEPS-1][b]);
                s = rnd_q15(cy_reg[CORDIC_STEPS-1][b]);
                q = d_reg[ST_RND-1][b*BOX_W+OFF_A+AW-2 +: 2];
                case (q)
                    QUAD_0:  begin cs_reg[ST_RND][b] <= c;  sn_reg[ST_RND][b] <= s;  end
                    QUAD_1:  begin cs_reg[ST_RND][b] <= -s; sn_reg[ST_RND][b] <= c;  end
                    QUAD_2:  begin cs_reg[ST_RND][b] <= -c; sn_reg[ST_RND][b] <= -s; end
                    default: begin cs_reg[ST_RND][b] <= s;  sn_reg[ST_RND][b] <= -c; end
                endcase
            end
            for (int s2 = ST_RND + 1; s2 < ST_PRM; s2++)
            begin
                cs_reg[s2] <= cs_reg[s2-1];
                sn_reg[s2] <= sn_reg[s2-1];
            end
        end
    end

    // ---------------- offset products ----------------
    logic signed [P_W-1:0] pwc_reg [2];
    logic signed [P_W-1:0] phs_reg [2];
    logic signed [P_W-1:0] pws_reg [2];
    logic signed [P_W-1:0] phc_reg [2];
    logic signed [CW-1:0]  ctx_reg [2];
    logic signed [CW-1:0]  cty_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 2; b++)
            begin
                logic signed [CW-1:0] w;
                logic signed [CW-1:0] h;
                w = $signed({1'b0, d_reg[ST_RND][b*BOX_W+OFF_W +: CW-1]});
                h = $signed({1'b0, d_reg[ST_RND][b*BOX_W+OFF_H +: CW-1]});
                pwc_reg[b] <= w * cs_reg[ST_RND][b];
                phs_reg[b] <= h * sn_reg[ST_RND][b];
                pws_reg[b] <= w * sn_reg[ST_RND][b];
                phc_reg[b] <= h * cs_reg[ST_RND][b];
                ctx_reg[b] <= $signed(d_reg[ST_RND][b*BOX_W +: CW]);
                cty_reg[b] <= $signed(d_reg[ST_RND][b*BOX_W+OFF_CY +: CW]);
            end
        end
    end

    // ---------------- corners, units of half a coordinate LSB ----------------
    logic signed [PX_W-1:0] px_reg [2][4];
    logic signed [PX_W-1:0] py_reg [2][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    logic signed [X_W-1:0] a1;
                    logic signed [X_W-1:0] a2;
                    logic signed [X_W-1:0] a3;
                    logic signed [X_W-1:0] a4;
                    logic signed [X_W-1:0] rx;
                    logic signed [X_W-1:0] ry;
                    a1 = X_W'(pwc_reg[b]);
                    a2 = X_W'(phs_reg[b]);
                    a3 = X_W'(pws_reg[b]);
                    a4 = X_W'(phc_reg[b]);
                    // corner signs: x negative for corners 0 and 3, y for 0 and 1
                    if (k == 0 || k == 3)
                    begin
                        a1 = -a1;
                        a3 = -a3;
                    end
                    if (k == 0 || k == 1)
                    begin
                        a2 = -a2;
                        a4 = -a4;
                    end
                    rx = (a1 - a2 + X_W'(16384)) >>> 15;
                    ry = (a3 + a4 + X_W'(16384)) >>> 15;
                    px_reg[b][k] <= PX_W'(rx) + (PX_W'(ctx_reg[b]) <<< 1);
                    py_reg[b][k] <= PX_W'(ry) + (PX_W'(cty_reg[b]) <<< 1);
                end
            end
        end
    end

    // ---------------- projections ----------------
    logic signed [PR_W-1:0] mx_reg [4][2][4];
    logic signed [PR_W-1:0] my_reg [4][2][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 4; ax++)
            begin
                logic signed [TRIG_W-1:0] ux;
                logic signed [TRIG_W-1:0] uy;
                if (ax[0] == 1'b0)
                begin
                    ux = cs_reg[ST_PRM-1][ax/2];
                    uy = sn_reg[ST_PRM-1][ax/2];
                end
                else
                begin
                    ux = -sn_reg[ST_PRM-1][ax/2];
                    uy = cs_reg[ST_PRM-1][ax/2];
                end
                for (int b = 0; b < 2; b++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        mx_reg[ax][b][k] <= ux * px_reg[b][k];
                        my_reg[ax][b][k] <= uy * py_reg[b][k];
                    end
                end
            end
        end
    end

    logic signed [SUM_W-1:0] pj_reg [4][2][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 4; ax++)
                for (int b = 0; b < 2; b++)
                    for (int k = 0; k < 4; k++)
                        pj_reg[ax][b][k] <= SUM_W'(mx_reg[ax][b][k]) + SUM_W'(my_reg[ax][b][k]);
        end
    end

    // ---------------- interval ends ----------------
    logic signed [SUM_W-1:0] lo_reg [4][2];
    logic signed [SUM_W-1:0] hi_reg [4][2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 4; ax++)
            begin
                for (int b = 0; b < 2; b++)
                begin
                    logic signed [SUM_W-1:0] l0;
                    logic signed [SUM_W-1:0] l1;
                    logic signed [SUM_W-1:0] h0;
                    logic signed [SUM_W-1:0] h1;
                    l0 = (pj_reg[ax][b][0] < pj_reg[ax][b][1]) ? pj_reg[ax][b][0] : pj_reg[ax][b][1];
                    h0 = (pj_reg[ax][b][0] < pj_reg[ax][b][1]) ? pj_reg[ax][b][1] : pj_reg[ax][b][0];
                    l1 = (pj_reg[ax][b][2] < pj_reg[ax][b][3]) ? pj_reg[ax][b][2] : pj_reg[ax][b][3];
                    h1 = (pj_reg[ax][b][2] < pj_reg[ax][b][3]) ? pj_reg[ax][b][3] : pj_reg[ax][b][2];
                    lo_reg[ax][b] <= (l0 < l1) ? l0 : l1;
                    hi_reg[ax][b] <= (h0 > h1) ? h0 : h1;
                end
            end
        end
    end

    // ---------------- gap test ----------------
    logic hit_reg;
    logic hit_next;

    always_comb
    begin
        hit_next = 1'b1;
        for (int ax = 0; ax < 4; ax++)
        begin
            if (hi_reg[ax][0] < lo_reg[ax][1] || hi_reg[ax][1] < lo_reg[ax][0])
                hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign m_tdata = {7'b0, hit_reg};

    // ---------------- assertions ----------------
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> $countones(v_reg) <= NST)
        else $error("valid count out of range");

endmodule
`default_nettype wire
